/* hw/rtl/ssrt_pkg.sv */
// ssrt_pkg: shared types and fixed field widths of the sorted score rank table
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package ssrt_pkg;

	// fixed widths of the channel fields
	localparam int OP_W    = 2;
	localparam int KEY_W   = 16;
	localparam int SCORE_W = 64;
	localparam int COUNT_W = 7;
	localparam int RANK_W  = 7;

	// request operation codes
	typedef enum logic [OP_W-1:0] {
		OP_SUBMIT = 2'd0,
		OP_TOPK   = 2'd1,
		OP_RANK   = 2'd2
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// sequencer states of the top level
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_SHIFT,
		S_PUT,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	// one result item as held in the output register
	typedef struct packed {
		status_t                    status;
		logic [KEY_W-1:0]           entry_key;
		logic signed [SCORE_W-1:0]  entry_score;
		logic [RANK_W-1:0]          rank;
		logic                       last;
	} rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/ssrt_req_if.sv */
// ssrt_req_if: request channel (valid/ready plus request fields)
// depends on ssrt_pkg for field widths
`default_nettype none

interface ssrt_req_if;
	import ssrt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           operation;
	logic [KEY_W-1:0]          user_key;
	logic signed [SCORE_W-1:0] score;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, output operation, output user_key, output score,
		output count, input ready);
	modport sink (input valid, input operation, input user_key, input score,
		input count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ssrt_rsp_if.sv */
// ssrt_rsp_if: result channel (valid/ready plus result fields)
// depends on ssrt_pkg for field widths and the status type
`default_nettype none

interface ssrt_rsp_if;
	import ssrt_pkg::*;

	logic                      valid;
	logic                      ready;
	status_t                   status;
	logic [KEY_W-1:0]          entry_key;
	logic signed [SCORE_W-1:0] entry_score;
	logic [RANK_W-1:0]         rank;
	logic                      last;

	modport source (output valid, output status, output entry_key, output entry_score,
		output rank, output last, input ready);
	modport sink (input valid, input status, input entry_key, input entry_score,
		input rank, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ssrt_ram.sv */
// ssrt_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module ssrt_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered: data appears in the cycle after the address
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sorted_score_rank_table.sv */
// Sorted score rank table: entries in one ram in rank order, one item at a time.
// Submit and rank query: a scan reads every entry, then a submit
// moves the entries between old and new place, one per cycle, and writes the new entry.
// Top-k: a ram read per result item, then a load into the result register that waits
// while the result stalls; then the next read. The ram has one read and one write port.
// Reset clears the entry count and the sequencer; the ram is not cleared.
`default_nettype none

module sorted_score_rank_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BITS    = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ssrt_req_if.sink   req,
	ssrt_rsp_if.source rsp
);
	import ssrt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = KEY_BITS + SCORE_W;

	state_t state_q, state_d;

	// control registers
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic             cmp_s1;
	logic             mv_s1;

	// working registers
	logic [1:0]                op_q;
	logic [KEY_BITS-1:0]       key_q;
	logic signed [SCORE_W-1:0] score_q;
	logic [CNT_W-1:0]          n_q;
	logic [IDX_W-1:0]          ptr_q;
	logic [IDX_W-1:0]          addr_s1;
	logic [IDX_W-1:0]          dst_s1;
	logic                      found_q;
	logic [IDX_W-1:0]          oldpos_q;
	logic signed [SCORE_W-1:0] fscore_q;
	logic [CNT_W-1:0]          before_q;
	logic [IDX_W-1:0]          newpos_q;
	logic [IDX_W-1:0]          end_q;
	logic                      up_q;
	rsp_t                      rsp_q;

	// ram ports
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata, mem_rdata;

	// combinational control
	logic             accept, out_free, res_load;
	rsp_t             res;
	logic [IDX_W-1:0] last_idx, newpos, shift_start;
	logic             shift_up, shift_need, emit_last;
	logic [CNT_W-1:0] topk_n;

	// entry fields coming out of the ram
	logic [KEY_BITS-1:0]       rd_key;
	logic signed [SCORE_W-1:0] rd_score;
	logic                      rd_before;

	assign rd_key   = mem_rdata[ENT_W-1:SCORE_W];
	assign rd_score = mem_rdata[SCORE_W-1:0];
	// stored entry ranks ahead of the submitted pair
	assign rd_before = (rd_score > score_q) || ((rd_score == score_q) && (rd_key < key_q));

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));
	assign newpos    = IDX_W'(before_q);
	assign emit_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == n_q);
	assign topk_n    = (req.count > COUNT_W'(cnt_q)) ? cnt_q : CNT_W'(req.count);

	// span of entries to move for a submit
	always_comb begin
		if (found_q) begin
			shift_up    = (newpos < oldpos_q);
			shift_need  = (newpos != oldpos_q);
			shift_start = shift_up ? (oldpos_q - IDX_W'(1)) : (oldpos_q + IDX_W'(1));
		end else begin
			shift_up    = 1'b1;
			shift_need  = (before_q < cnt_q);
			shift_start = last_idx;
		end
	end

	// next state, ram reads and result loads
	always_comb begin
		state_d  = state_q;
		mem_re   = 1'b0;
		res_load = 1'b0;
		res      = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.operation)
						OP_SUBMIT, OP_RANK: state_d = (cnt_q == '0) ? S_DECIDE : S_SCAN;
						OP_TOPK:            state_d = S_EMIT_RD;
						default:            state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				mem_re = 1'b1;
				if (ptr_q == last_idx) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (op_q == OP_RANK) begin
					if (out_free) begin
						res_load      = 1'b1;
						res.entry_key = KEY_W'(key_q);
						res.last      = 1'b1;
						if (found_q) begin
							res.status      = ST_OK;
							res.entry_score = fscore_q;
							res.rank        = RANK_W'(oldpos_q) + RANK_W'(1);
						end else begin
							res.status = ST_NOT_FOUND;
						end
						state_d = S_IDLE;
					end
				end else if (!found_q && (cnt_q == CNT_W'(TABLE_DEPTH))) begin
					if (out_free) begin
						res_load        = 1'b1;
						res.status      = ST_FULL;
						res.entry_key   = KEY_W'(key_q);
						res.entry_score = score_q;
						res.last        = 1'b1;
						state_d         = S_IDLE;
					end
				end else begin
					state_d = shift_need ? S_SHIFT : S_PUT;
				end
			end
			S_SHIFT: begin
				mem_re = 1'b1;
				if (ptr_q == end_q) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				if (!mv_s1 && out_free) begin
					res_load        = 1'b1;
					res.status      = ST_OK;
					res.entry_key   = KEY_W'(key_q);
					res.entry_score = score_q;
					res.rank        = RANK_W'(newpos_q) + RANK_W'(1);
					res.last        = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_EMIT_RD: begin
				if (n_q == '0) begin
					if (out_free) begin
						res_load   = 1'b1;
						res.status = ST_EMPTY;
						res.last   = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					mem_re  = 1'b1;
					state_d = S_EMIT_LD;
				end
			end
			S_EMIT_LD: begin
				if (out_free) begin
					res_load        = 1'b1;
					res.status      = ST_OK;
					res.entry_key   = KEY_W'(rd_key);
					res.entry_score = rd_score;
					res.rank        = RANK_W'(ptr_q) + RANK_W'(1);
					res.last        = emit_last;
					state_d         = emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ram write: moved entry has priority, then the new entry
	always_comb begin
		mem_we    = mv_s1 || ((state_q == S_PUT) && out_free);
		mem_waddr = mv_s1 ? dst_s1 : newpos_q;
		mem_wdata = mv_s1 ? mem_rdata : {key_q, score_q};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// entry count, result valid and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			cmp_s1      <= 1'b0;
			mv_s1       <= 1'b0;
		end else begin
			cmp_s1 <= (state_q == S_SCAN);
			mv_s1  <= (state_q == S_SHIFT);
			if (res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if ((state_q == S_PUT) && !mv_s1 && out_free && !found_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// request latch, scan results and walk pointer
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q;
		if (accept) begin
			op_q     <= req.operation;
			key_q    <= KEY_BITS'(req.user_key);
			score_q  <= req.score;
			n_q      <= topk_n;
			ptr_q    <= '0;
			found_q  <= 1'b0;
			before_q <= '0;
		end
		if (state_q == S_SCAN) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
		// compare the entry read in the previous cycle
		if (cmp_s1) begin
			if (rd_key == key_q) begin
				found_q  <= 1'b1;
				oldpos_q <= addr_s1;
				fscore_q <= rd_score;
			end else if (rd_before) begin
				before_q <= before_q + CNT_W'(1);
			end
		end
		if (state_q == S_DECIDE) begin
			newpos_q <= newpos;
			end_q    <= newpos;
			up_q     <= shift_up;
			ptr_q    <= shift_start;
		end
		// move one entry a slot up or down
		if (state_q == S_SHIFT) begin
			dst_s1 <= up_q ? (ptr_q + IDX_W'(1)) : (ptr_q - IDX_W'(1));
			ptr_q  <= up_q ? (ptr_q - IDX_W'(1)) : (ptr_q + IDX_W'(1));
		end
		if ((state_q == S_EMIT_LD) && out_free && !emit_last) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
		if (res_load) begin
			rsp_q <= res;
		end
	end

	ssrt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	// result channel
	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.entry_key   = rsp_q.entry_key;
	assign rsp.entry_score = rsp_q.entry_score;
	assign rsp.rank        = rsp_q.rank;
	assign rsp.last        = rsp_q.last;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_cnt_only_put: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(state_q) == S_PUT)
		else $error("entry count changed outside the insert step");

	a_move_window: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |-> (state_q == S_SHIFT || state_q == S_PUT))
		else $error("entry move write outside a submit");

	a_move_dst: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |-> CNT_W'(dst_s1) <= cnt_q)
		else $error("entry moved past the end of the table");

	a_emit_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT_LD |-> CNT_W'(ptr_q) < n_q)
		else $error("top-k read beyond requested count");

endmodule

`default_nettype wire

/* tb/sv/sorted_score_rank_table_tb.sv */
`timescale 1ns / 1ps
// sorted_score_rank_table_tb: self-checking bench for the sorted score rank table
// depends on ssrt_pkg, ssrt_req_if, ssrt_rsp_if and the sorted_score_rank_table top level

module sorted_score_rank_table_tb;
	import ssrt_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS    = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 300;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 64'sh8000_0000_0000_0000;
	localparam logic [OP_W-1:0]           OP_SPARE  = 2'd3;

	// one pending request, or a hold that waits for all results to drain
	typedef struct {
		bit                        hold;
		logic [OP_W-1:0]           op;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
		logic [COUNT_W-1:0]        count;
	} score_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// bench-side drive registers, known from time zero
	logic                      drv_valid = 1'b0;
	logic [OP_W-1:0]           drv_op    = '0;
	logic [KEY_W-1:0]          drv_key   = '0;
	logic signed [SCORE_W-1:0] drv_score = '0;
	logic [COUNT_W-1:0]        drv_count = '0;
	logic                      drv_ready = 1'b0;

	score_req_t pending_reqs[$];
	score_req_t in_flight;
	rsp_t       expected_rsps[$];
	int         total_reqs = 0;
	int         accepted_reqs = 0;
	int         rsp_seen = 0;
	int         mismatches = 0;
	int         cycles = 0;

	// shadow of the ranked table
	logic [KEY_W-1:0]          tbl_key   [TABLE_DEPTH];
	logic signed [SCORE_W-1:0] tbl_score [TABLE_DEPTH];
	int                        tbl_used = 0;

	ssrt_req_if req_ch ();
	ssrt_rsp_if rsp_ch ();

	assign req_ch.valid     = drv_valid;
	assign req_ch.operation = drv_op;
	assign req_ch.user_key  = drv_key;
	assign req_ch.score     = drv_score;
	assign req_ch.count     = drv_count;
	assign rsp_ch.ready     = drv_ready;

	sorted_score_rank_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle rates per phase of the run
	function automatic int send_idle_pct();
		if (accepted_reqs < total_reqs / 3)
			return 32;
		if (accepted_reqs < (2 * total_reqs) / 3)
			return 54;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (accepted_reqs < total_reqs / 3)
			return 54;
		if (accepted_reqs < (2 * total_reqs) / 3)
			return 32;
		return 0;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void push_result(input status_t st, input logic [KEY_W-1:0] key,
		input logic signed [SCORE_W-1:0] score, input int rank, input bit last);
		rsp_t r;
		r.status      = st;
		r.entry_key   = key;
		r.entry_score = score;
		r.rank        = RANK_W'(rank);
		r.last        = last;
		expected_rsps = {expected_rsps, r};
	endfunction

	// higher score first, then lower key
	function automatic bit ranks_ahead(input logic signed [SCORE_W-1:0] sa,
		input logic [KEY_W-1:0] ka, input logic signed [SCORE_W-1:0] sb,
		input logic [KEY_W-1:0] kb);
		if (sa != sb)
			return sa > sb;
		return ka < kb;
	endfunction

	// apply one accepted request to the shadow table and queue its results
	task automatic rank_table_apply(input score_req_t r);
		int pos;
		int i;
		int n;
		pos = tbl_used;
		for (i = 0; i < tbl_used; i++) begin
			if (tbl_key[i] == r.key) begin
				pos = i;
				break;
			end
		end
		case (r.op)
			OP_SUBMIT: begin
				if (pos < tbl_used) begin
					// drop the old entry of this key
					for (i = pos; i + 1 < tbl_used; i++) begin
						tbl_key[i]   = tbl_key[i + 1];
						tbl_score[i] = tbl_score[i + 1];
					end
					tbl_used--;
				end else if (tbl_used >= TABLE_DEPTH) begin
					push_result(ST_FULL, r.key, r.score, 0, 1'b1);
					return;
				end
				pos = 0;
				while (pos < tbl_used && ranks_ahead(tbl_score[pos], tbl_key[pos], r.score, r.key))
					pos++;
				for (i = tbl_used; i > pos; i--) begin
					tbl_key[i]   = tbl_key[i - 1];
					tbl_score[i] = tbl_score[i - 1];
				end
				tbl_key[pos]   = r.key;
				tbl_score[pos] = r.score;
				tbl_used++;
				push_result(ST_OK, r.key, r.score, pos + 1, 1'b1);
			end
			OP_TOPK: begin
				n = (int'(r.count) > tbl_used) ? tbl_used : int'(r.count);
				if (n == 0) begin
					push_result(ST_EMPTY, '0, '0, 0, 1'b1);
				end else begin
					for (i = 0; i < n; i++)
						push_result(ST_OK, tbl_key[i], tbl_score[i], i + 1, i + 1 == n);
				end
			end
			OP_RANK: begin
				if (pos < tbl_used)
					push_result(ST_OK, r.key, tbl_score[pos], pos + 1, 1'b1);
				else
					push_result(ST_NOT_FOUND, r.key, '0, 0, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic signed [SCORE_W-1:0] score, input int count);
		score_req_t r;
		r.hold  = 1'b0;
		r.op    = op;
		r.key   = key;
		r.score = score;
		r.count = COUNT_W'(count);
		pending_reqs = {pending_reqs, r};
		total_reqs++;
	endtask

	task automatic add_hold();
		score_req_t r;
		r       = '{default: 0};
		r.hold  = 1'b1;
		pending_reqs = {pending_reqs, r};
	endtask

	// extremes, near-zero ties and full random scores
	function automatic logic signed [SCORE_W-1:0] random_score();
		int v;
		case ($urandom_range(0, 5))
			0: return SCORE_MAX;
			1: return SCORE_MIN;
			2: begin
				v = $urandom_range(0, 8);
				v = v - 4;
				return SCORE_W'(v);
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// mixed traffic; new_pct sets how often a submit, rank or spare request names a fresh random key
	task automatic random_mix(input int n, input int new_pct);
		int r;
		logic [KEY_W-1:0] key;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < new_pct)
				key = KEY_W'($urandom_range(0, 65535));
			else if ($urandom_range(0, 1) == 0)
				key = KEY_W'($urandom_range(0, 15));
			else
				key = KEY_W'(32'h0100 + $urandom_range(0, 63));
			if (r < 45)
				add_req(OP_SUBMIT, key, random_score(), 0);
			else if (r < 70)
				add_req(OP_RANK, key, random_score(), $urandom_range(0, 64));
			else if (r < 96)
				add_req(OP_TOPK, KEY_W'($urandom), random_score(),
					($urandom_range(0, 99) < 70) ? $urandom_range(0, 8) : $urandom_range(0, 64));
			else
				add_req(OP_SPARE, key, random_score(), $urandom_range(0, 64));
		end
	endtask

	// request driver
	always @(posedge clk) begin : drive_req
		bit         nv;
		score_req_t it;
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			nv = drv_valid;
			if (drv_valid && req_ch.ready) begin
				rank_table_apply(in_flight);
				accepted_reqs++;
				nv = 1'b0;
			end
			if (!nv && pending_reqs.size() > 0) begin
				if (pending_reqs[0].hold) begin
					// hold off until every result has come back
					if (expected_rsps.size() == 0)
						void'(pending_reqs.pop_front());
				end else if ($urandom_range(0, 99) >= send_idle_pct()) begin
					it        = pending_reqs.pop_front();
					in_flight = it;
					nv        = 1'b1;
					drv_op    <= it.op;
					drv_key   <= it.key;
					drv_score <= it.score;
					drv_count <= it.count;
				end
			end
			drv_valid <= nv;
		end
	end

	// result checker and receiver stalls
	always @(posedge clk) begin : check_rsp
		rsp_t got;
		rsp_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[%0t] timeout with %0d results outstanding", $realtime,
				expected_rsps.size());
			$display("Mismatches found");
			$finish;
		end else if (!arst_n) begin
			drv_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && drv_ready) begin
				got.status      = rsp_ch.status;
				got.entry_key   = rsp_ch.entry_key;
				got.entry_score = rsp_ch.entry_score;
				got.rank        = rsp_ch.rank;
				got.last        = rsp_ch.last;
				if (expected_rsps.size() == 0) begin
					report_mismatch($sformatf("result %0d with none expected: st=%0d key=%h",
						rsp_seen, got.status, got.entry_key));
				end else begin
					want = expected_rsps.pop_front();
					if (got !== want)
						report_mismatch($sformatf(
							"result %0d got st=%0d key=%h sc=%h rk=%0d l=%b want st=%0d key=%h sc=%h rk=%0d l=%b",
							rsp_seen, got.status, got.entry_key, got.entry_score, got.rank, got.last,
							want.status, want.entry_key, want.entry_score, want.rank, want.last));
				end
				rsp_seen++;
			end
			drv_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
		end
	end

	// stimulus, reset and end of run
	initial begin
		// directed: empty table, extremes, ties, replacement, saturation
		add_req(OP_TOPK, 16'h0000, '0, 64);
		add_req(OP_RANK, 16'hFFFF, '0, 0);
		add_req(OP_SUBMIT, 16'hFFFF, SCORE_MAX, 0);
		add_req(OP_SUBMIT, 16'h0000, SCORE_MIN, 0);
		add_req(OP_SUBMIT, 16'h0005, 64'sd0, 0);
		add_req(OP_SUBMIT, 16'h0003, 64'sd0, 0);
		add_req(OP_SUBMIT, 16'h0005, -64'sd1, 0);
		add_req(OP_SUBMIT, 16'h0003, 64'sd0, 0);
		add_req(OP_RANK, 16'h0003, SCORE_MAX, 0);
		add_req(OP_RANK, 16'h0000, '0, 0);
		add_req(OP_RANK, 16'h1234, '0, 0);
		add_req(OP_TOPK, 16'h0000, '0, 0);
		add_req(OP_TOPK, 16'hFFFF, '0, 2);
		add_req(OP_TOPK, 16'h0000, '0, 64);
		add_req(OP_SPARE, 16'hFFFF, -64'sd1, 64);
		add_req(OP_SUBMIT, 16'h00FF, 64'sh5555_5555_5555_5555, 0);
		add_req(OP_SUBMIT, 16'hAAAA, 64'shAAAA_AAAA_AAAA_AAAA, 0);
		add_req(OP_TOPK, 16'h0000, '0, 1);
		add_hold();

		// random traffic over a small key pool
		random_mix(60, 10);
		add_hold();

		// fill the table so that fresh keys get refused
		for (int k = 0; k < TABLE_DEPTH; k++)
			add_req(OP_SUBMIT, KEY_W'(32'h0100 + k), random_score(), 0);
		add_req(OP_TOPK, 16'h0000, '0, 64);
		random_mix(40, 40);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_reqs.size() != 0 || drv_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/ssrt_pkg.sv
hw/rtl/ssrt_req_if.sv
hw/rtl/ssrt_rsp_if.sv
hw/rtl/ssrt_ram.sv
hw/rtl/sorted_score_rank_table.sv
tb/sv/sorted_score_rank_table_tb.sv
